[hdl/hbsd_pkg.sv]
package hbsd_pkg;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] mapped_address;
    logic [7:0]  store_value;
    logic        dma_start;
    logic [7:0]  dma_source_page;
    logic        timer_control_changed;
  } out_t;

  // target codes
  localparam logic [2:0] TGT_ROM  = 3'd0;
  localparam logic [2:0] TGT_RAM  = 3'd1;
  localparam logic [2:0] TGT_INT  = 3'd2;
  localparam logic [2:0] TGT_JOY  = 3'd3;
  localparam logic [2:0] TGT_DROP = 3'd4;

  // controller types
  localparam logic [1:0] CT_NONE = 2'd0;
  localparam logic [1:0] CT_MBC1 = 2'd1;
  localparam logic [1:0] CT_MBC2 = 2'd2;

  localparam logic       ACT_READ  = 1'b0;
  localparam logic       ACT_WRITE = 1'b1;

  localparam logic [15:0] ADDR_BANK1    = 16'h4000;
  localparam logic [15:0] ADDR_VRAM     = 16'h8000;
  localparam logic [15:0] ADDR_CART_RAM = 16'hA000;
  localparam logic [15:0] ADDR_WRAM     = 16'hC000;
  localparam logic [15:0] ADDR_ECHO     = 16'hE000;
  localparam logic [15:0] ADDR_OAM      = 16'hFE00;
  localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
  localparam logic [15:0] ADDR_UNUS_END = 16'hFEFF;
  localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_TAC      = 16'hFF07;
  localparam logic [15:0] ADDR_LY       = 16'hFF44;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ECHO_FOLD     = 16'h2000;

  localparam logic [3:0]  RAM_EN_KEY = 4'hA;

  // bank controller register windows, address bits 14:13 below 0x8000
  localparam logic [1:0] WIN_RAM_EN   = 2'd0;
  localparam logic [1:0] WIN_ROM_LO   = 2'd1;
  localparam logic [1:0] WIN_BANK_HI  = 2'd2;
  localparam logic [1:0] WIN_MODE     = 2'd3;

endpackage

[hdl/handheld_bank_switch_bus_decoder.sv]
// Timing: the result of an accepted transaction is registered and shows on out_* in the next cycle,
// held until out_ready takes it.
// Throughput: one transaction per cycle while out_ready takes results; the single result register
// is the only stage, and in_ready stays high while that register drains.
// Reset (rst, synchronous): bank registers to ROM bank 1, RAM bank 0, RAM disabled,
// RAM banking mode, timer control copy 0, controller type none, output empty.
module handheld_bank_switch_bus_decoder
  import hbsd_pkg::*;
#(
  parameter int ROM_BANK_BITS  = 7,
  parameter int RAM_BANK_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  // only the low bits that the masked bank can ever show are kept
  localparam int RB_W = (ROM_BANK_BITS < 7) ? ROM_BANK_BITS : 7;

  // RAM bank is stored already reduced modulo the bank count
  localparam logic [1:0] RAM_MOD [4] = '{
    2'(0 % RAM_BANK_COUNT), 2'(1 % RAM_BANK_COUNT),
    2'(2 % RAM_BANK_COUNT), 2'(3 % RAM_BANK_COUNT)
  };

  logic [1:0]      ctrl_type;
  logic [RB_W-1:0] rom_bank, rom_bank_next;
  logic [1:0]      ram_bank, ram_bank_next;
  logic            ram_enabled, ram_enabled_next;
  logic            rom_banking_mode, rom_banking_mode_next;
  logic [7:0]      timer_control_copy, timer_control_copy_next;

  logic        accept;
  logic        wr;
  logic [15:0] addr;
  logic [7:0]  data;
  logic        mbc1, mbc2, mbc;
  logic [6:0]  rb7, rb7_new;
  logic [3:0]  lo4;
  logic [4:0]  lo5;
  logic [6:0]  rom_sel;
  logic [1:0]  ram_sel;
  logic        ram_access_ok;
  out_t        res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign wr   = (in_data.action == ACT_WRITE);
  assign data = in_data.write_byte;
  assign mbc1 = (ctrl_type == CT_MBC1);
  assign mbc2 = (ctrl_type == CT_MBC2);
  assign mbc  = mbc1 || mbc2;

  // echo RAM folds onto work RAM
  always_comb begin
    addr = in_data.bus_address;
    if (addr >= ADDR_ECHO && addr < ADDR_OAM) begin
      addr = addr - ECHO_FOLD;
    end
  end

  assign rb7 = 7'(rom_bank);
  assign lo4 = (data[3:0] == 4'd0) ? 4'd1 : data[3:0];
  assign lo5 = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];

  // bank controller register writes
  always_comb begin
    rb7_new               = rb7;
    ram_bank_next         = ram_bank;
    ram_enabled_next      = ram_enabled;
    rom_banking_mode_next = rom_banking_mode;
    if (wr && !addr[15] && mbc) begin
      unique case (addr[14:13])
        WIN_RAM_EN: begin
          if (!(mbc2 && addr[8])) begin
            ram_enabled_next = (data[3:0] == RAM_EN_KEY);
          end
        end
        WIN_ROM_LO: begin
          if (mbc2) begin
            rb7_new = {3'd0, lo4};
          end else begin
            rb7_new = {rb7[6:5], lo5};
          end
        end
        WIN_BANK_HI: begin
          if (mbc1) begin
            if (rom_banking_mode) begin
              rb7_new = {data[1:0], rb7[4:0]};
            end else begin
              ram_bank_next = RAM_MOD[data[1:0]];
            end
          end
        end
        default: begin
          if (mbc1) begin
            if (data[0]) begin
              rom_banking_mode_next = 1'b0;
              rb7_new               = {2'd0, rb7[4:0]};
            end else begin
              rom_banking_mode_next = 1'b1;
              ram_bank_next         = 2'd0;
            end
          end
        end
      endcase
    end
    rom_bank_next = rb7_new[RB_W-1:0];
  end

  assign rom_sel       = mbc ? rb7 : 7'd1;
  assign ram_sel       = mbc1 ? ram_bank : 2'd0;
  assign ram_access_ok = mbc ? ram_enabled : 1'b1;

  // result decode
  always_comb begin
    res                     = '0;
    res.target              = TGT_INT;
    timer_control_copy_next = timer_control_copy;
    if (!addr[15]) begin
      if (wr) begin
        res.target = TGT_DROP;
      end else if (addr < ADDR_BANK1) begin
        res.target         = TGT_ROM;
        res.mapped_address = 21'(addr);
      end else begin
        res.target         = TGT_ROM;
        res.mapped_address = {rom_sel, addr[13:0]};
      end
    end else if (addr >= ADDR_UNUSABLE && addr <= ADDR_UNUS_END) begin
      res.target = TGT_DROP;
    end else if (addr >= ADDR_CART_RAM && addr < ADDR_WRAM) begin
      if (wr && !ram_access_ok) begin
        res.target = TGT_DROP;
      end else begin
        res.target         = TGT_RAM;
        res.mapped_address = 21'({ram_sel, addr[12:0]});
        res.store_value    = wr ? data : 8'd0;
      end
    end else if (addr == ADDR_JOYPAD) begin
      res.target      = TGT_JOY;
      res.store_value = wr ? data : 8'd0;
    end else begin
      res.mapped_address = 21'(addr);
      if (wr) begin
        // divider and line counter reset on any write
        res.store_value = (addr == ADDR_DIV || addr == ADDR_LY) ? 8'd0 : data;
        if (addr == ADDR_DMA) begin
          res.dma_start       = 1'b1;
          res.dma_source_page = data;
        end
        if (addr == ADDR_TAC) begin
          res.timer_control_changed = (data != timer_control_copy);
          timer_control_copy_next   = data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_type          <= CT_NONE;
      rom_bank           <= RB_W'(1);
      ram_bank           <= 2'd0;
      ram_enabled        <= 1'b0;
      rom_banking_mode   <= 1'b0;
      timer_control_copy <= 8'd0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        ctrl_type <= cfg_wdata;
      end
      if (accept) begin
        rom_bank           <= rom_bank_next;
        ram_bank           <= ram_bank_next;
        ram_enabled        <= ram_enabled_next;
        rom_banking_mode   <= rom_banking_mode_next;
        timer_control_copy <= timer_control_copy_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

[hdl/hbsd_checker.sv]
module hbsd_checker
  import hbsd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // in the cycle after reset is seen the result register is empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // every accepted transaction lands in the result register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // dma start only on internal register writes to the dma address
  a_dma_decode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dma_start) |->
      (out_data.target == TGT_INT && out_data.mapped_address == 21'(ADDR_DMA)))
    else $error("dma start on wrong address");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.target == TGT_DROP) |->
      (out_data.mapped_address == 21'd0 && out_data.store_value == 8'd0 &&
       !out_data.dma_start && !out_data.timer_control_changed))
    else $error("dropped transaction carries data");

endmodule

bind handheld_bank_switch_bus_decoder hbsd_checker u_hbsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/tb_handheld_bank_switch_bus_decoder.sv]
module tb_handheld_bank_switch_bus_decoder;
  import hbsd_pkg::*;

  localparam logic [1:0] CT_UNKNOWN = 2'd3;
  localparam int GAP_MAX = 14;
  localparam int LONG_HOLD = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 75;
  localparam logic [1:0] PHASE_CFG [PHASES] = '{CT_MBC1, CT_NONE, CT_MBC2, CT_UNKNOWN,
                                                CT_MBC1, CT_MBC2, CT_MBC1, CT_NONE};

  typedef struct {
    logic [1:0] ctype;
    in_t        acc;
    bit         typed;
    out_t       res;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  handheld_bank_switch_bus_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the bank controller
  logic [1:0] ctl_type;
  logic [6:0] rom_bank_q;
  logic [1:0] ram_bank_q;
  logic ram_on;
  logic rom_mode;
  logic [7:0] tac_copy;

  out_t routes_due[$];
  vec_t dir_vecs[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int src_max = GAP_MAX;
  int snk_max = GAP_MAX;
  int hold_reqs = 0;
  int holds_done = 0;

  function automatic out_t route_access(in_t acc);
    out_t r;
    logic [15:0] a;
    logic [7:0] d;
    logic mbc;
    logic ram_ok;
    logic [1:0] rbank;
    r = '0;
    r.target = TGT_INT;
    a = acc.bus_address;
    d = acc.write_byte;
    mbc = (ctl_type == CT_MBC1) || (ctl_type == CT_MBC2);
    if (a >= ADDR_ECHO && a < ADDR_OAM) a = a - ECHO_FOLD;
    if (a < ADDR_VRAM) begin
      if (acc.action == ACT_WRITE) begin
        r.target = TGT_DROP;
        if (mbc) begin
          case (a[14:13])
            WIN_RAM_EN: begin
              // MBC2 only listens with address bit 8 clear
              if (ctl_type == CT_MBC1 || !a[8]) ram_on = (d[3:0] == RAM_EN_KEY);
            end
            WIN_ROM_LO: begin
              if (ctl_type == CT_MBC2) rom_bank_q = (d[3:0] == 4'd0) ? 7'd1 : {3'd0, d[3:0]};
              else rom_bank_q = {rom_bank_q[6:5], (d[4:0] == 5'd0) ? 5'd1 : d[4:0]};
            end
            WIN_BANK_HI: begin
              if (ctl_type == CT_MBC1) begin
                if (rom_mode) rom_bank_q[6:5] = d[1:0];
                else ram_bank_q = d[1:0];
              end
            end
            default: begin
              if (ctl_type == CT_MBC1) begin
                if (d[0]) begin
                  rom_mode = 1'b0;
                  rom_bank_q[6:5] = 2'd0;
                end else begin
                  rom_mode = 1'b1;
                  ram_bank_q = 2'd0;
                end
              end
            end
          endcase
        end
      end else if (a < ADDR_BANK1) begin
        r.target = TGT_ROM;
        r.mapped_address = {5'd0, a};
      end else begin
        r.target = TGT_ROM;
        r.mapped_address = {(mbc ? rom_bank_q : 7'd1), a[13:0]};
      end
    end else if (a >= ADDR_UNUSABLE && a <= ADDR_UNUS_END) begin
      r.target = TGT_DROP;
    end else if (a >= ADDR_CART_RAM && a < ADDR_WRAM) begin
      rbank = (ctl_type == CT_MBC1) ? ram_bank_q : 2'd0;
      ram_ok = mbc ? ram_on : 1'b1;
      if (acc.action == ACT_WRITE && !ram_ok) begin
        r.target = TGT_DROP;
      end else begin
        r.target = TGT_RAM;
        r.mapped_address = {6'd0, rbank, a[12:0]};
        if (acc.action == ACT_WRITE) r.store_value = d;
      end
    end else if (a == ADDR_JOYPAD) begin
      r.target = TGT_JOY;
      if (acc.action == ACT_WRITE) r.store_value = d;
    end else begin
      r.mapped_address = {5'd0, a};
      if (acc.action == ACT_WRITE) begin
        r.store_value = (a == ADDR_DIV || a == ADDR_LY) ? 8'd0 : d;
        if (a == ADDR_DMA) begin
          r.dma_start = 1'b1;
          r.dma_source_page = d;
        end
        if (a == ADDR_TAC) begin
          r.timer_control_changed = (d != tac_copy);
          tac_copy = d;
        end
      end
    end
    return r;
  endfunction

  function automatic in_t gen_access();
    in_t acc;
    int pick;
    acc.action = 1'($urandom_range(0, 1));
    acc.bus_address = 16'($urandom);
    acc.write_byte = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // bank controller programming, biased toward enable key and bank zero
      acc.action = ACT_WRITE;
      acc.bus_address = 16'($urandom_range(0, ADDR_VRAM - 1));
      if ($urandom_range(0, 1) == 1) acc.write_byte[3:0] = RAM_EN_KEY;
      if ($urandom_range(0, 5) == 0) acc.write_byte[4:0] = 5'd0;
    end else if (pick < 45) begin
      acc.action = ACT_READ;
      acc.bus_address = 16'($urandom_range(0, ADDR_VRAM - 1));
    end else if (pick < 65) begin
      acc.bus_address = 16'($urandom_range(ADDR_CART_RAM, ADDR_WRAM - 1));
    end else if (pick < 73) begin
      acc.bus_address = 16'($urandom_range(ADDR_ECHO, ADDR_OAM - 1));
    end else if (pick < 78) begin
      acc.bus_address = 16'($urandom_range(ADDR_UNUSABLE, ADDR_UNUS_END));
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: acc.bus_address = ADDR_JOYPAD;
        1: acc.bus_address = ADDR_DIV;
        2: acc.bus_address = ADDR_LY;
        3: acc.bus_address = ADDR_DMA;
        default: begin
          // small values so repeats of the timer control value occur
          acc.bus_address = ADDR_TAC;
          acc.write_byte = 8'($urandom_range(0, 3));
        end
      endcase
    end
    return acc;
  endfunction

  task automatic add_row(logic [1:0] ct, logic act, logic [15:0] addr, logic [7:0] data,
                         bit typed, logic [2:0] tgt, logic [20:0] map, logic [7:0] st,
                         logic dma, logic [7:0] pg, logic tc);
    vec_t v;
    v.ctype = ct;
    v.acc.action = act;
    v.acc.bus_address = addr;
    v.acc.write_byte = data;
    v.typed = typed;
    v.res.target = tgt;
    v.res.mapped_address = map;
    v.res.store_value = st;
    v.res.dma_start = dma;
    v.res.dma_source_page = pg;
    v.res.timer_control_changed = tc;
    dir_vecs.push_back(v);
  endtask

  task automatic send_access(in_t acc, bit typed, out_t res);
    int gap;
    out_t pred;
    gap = $urandom_range(0, src_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    do @(posedge clk); while (!in_ready);
    pred = route_access(acc);
    routes_due.push_back(typed ? res : pred);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (routes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_controller(logic [1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ctl_type = v;
  endtask

  initial begin : sink
    int stall;
    out_t got;
    out_t want;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (holds_done < hold_reqs) begin
        // long back-pressure so the result register fills and input stalls
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        stall = $urandom_range(0, snk_max);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (routes_due.size() == 0) begin
        $error("unexpected transaction: target %0d address 0x%06h", got.target,
               got.mapped_address);
        errors++;
      end else begin
        want = routes_due.pop_front();
        n_checked++;
        if (got.target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, got.target);
          errors++;
        end
        if (got.mapped_address !== want.mapped_address) begin
          $error("mapped_address: expected 0x%06h, got 0x%06h", want.mapped_address,
                 got.mapped_address);
          errors++;
        end
        if (got.store_value !== want.store_value) begin
          $error("store_value: expected 0x%02h, got 0x%02h", want.store_value,
                 got.store_value);
          errors++;
        end
        if (got.dma_start !== want.dma_start) begin
          $error("dma_start: expected %0d, got %0d", want.dma_start, got.dma_start);
          errors++;
        end
        if (got.dma_source_page !== want.dma_source_page) begin
          $error("dma_source_page: expected 0x%02h, got 0x%02h", want.dma_source_page,
                 got.dma_source_page);
          errors++;
        end
        if (got.timer_control_changed !== want.timer_control_changed) begin
          $error("timer_control_changed: expected %0d, got %0d",
                 want.timer_control_changed, got.timer_control_changed);
          errors++;
        end
      end
    end
  end

  initial begin : stim
    int p;
    int i;
    cfg_we = 1'b0;
    cfg_wdata = CT_NONE;
    in_valid = 1'b0;
    in_data = '0;
    ctl_type = CT_NONE;
    rom_bank_q = 7'd1;
    ram_bank_q = 2'd0;
    ram_on = 1'b0;
    rom_mode = 1'b0;
    tac_copy = 8'd0;

    // no controller: fixed map, always-on cart RAM, I/O special cases
    add_row(CT_NONE, ACT_READ,  16'h0000, 8'h00, 1, TGT_ROM,  21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'h2000, 8'h05, 1, TGT_DROP, 21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hA000, 8'h5A, 1, TGT_RAM,  21'h000000, 8'h5A, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_READ,  16'hBFFF, 8'hFF, 1, TGT_RAM,  21'h001FFF, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hE000, 8'hA5, 1, TGT_INT,  21'h00C000, 8'hA5, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_READ,  16'hFEA0, 8'h00, 1, TGT_DROP, 21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hFEFF, 8'h33, 1, TGT_DROP, 21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hFF00, 8'h30, 1, TGT_JOY,  21'h000000, 8'h30, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hFF04, 8'h77, 1, TGT_INT,  21'h00FF04, 8'h00, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hFF46, 8'hC1, 1, TGT_INT,  21'h00FF46, 8'hC1, 1, 8'hC1, 0);
    add_row(CT_NONE, ACT_WRITE, 16'hFF07, 8'h05, 1, TGT_INT,  21'h00FF07, 8'h05, 0, 8'h00, 1);
    add_row(CT_NONE, ACT_WRITE, 16'hFF07, 8'h05, 1, TGT_INT,  21'h00FF07, 8'h05, 0, 8'h00, 0);
    add_row(CT_NONE, ACT_READ,  16'hFFFF, 8'h00, 1, TGT_INT,  21'h00FFFF, 8'h00, 0, 8'h00, 0);
    // MBC1: disabled RAM write, enable, bank zero, both banking modes
    add_row(CT_MBC1, ACT_WRITE, 16'hA000, 8'h11, 1, TGT_DROP, 21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h1FFF, 8'h0A, 1, TGT_DROP, 21'h000000, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h2000, 8'h00, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h4000, 8'h03, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'hBFFF, 8'hAB, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h6000, 8'h00, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h5FFF, 8'hFF, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_WRITE, 16'h3FFF, 8'h1F, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC1, ACT_READ,  16'h7FFF, 8'h00, 1, TGT_ROM,  21'h1FFFFF, 8'h00, 0, 8'h00, 0);
    // MBC2: address bit 8 gate on enable, 4-bit ROM bank
    add_row(CT_MBC2, ACT_WRITE, 16'h0000, 8'h00, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC2, ACT_WRITE, 16'h0100, 8'h0A, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC2, ACT_WRITE, 16'hA123, 8'h44, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC2, ACT_WRITE, 16'h2100, 8'h00, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);
    add_row(CT_MBC2, ACT_READ,  16'h4000, 8'h00, 0, TGT_ROM,  21'h0, 8'h00, 0, 8'h00, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_vecs[k]) begin
      if (dir_vecs[k].ctype != ctl_type) begin
        drain();
        set_controller(dir_vecs[k].ctype);
      end
      send_access(dir_vecs[k].acc, dir_vecs[k].typed, dir_vecs[k].res);
    end

    for (p = 0; p < PHASES; p++) begin
      drain();
      set_controller(PHASE_CFG[p]);
      // phase 2 runs back to back; phase 3 streams into a long output stall
      src_max = (p == 2 || p == 3) ? 0 : GAP_MAX;
      snk_max = (p == 2) ? 0 : GAP_MAX;
      if (p == 3) hold_reqs++;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) drain();
        send_access(gen_access(), 1'b0, '0);
      end
    end
    drain();
    repeat (5) @(posedge clk);

    $display("%0d transactions sent, %0d compared, over %0d controller settings",
             n_sent, n_checked, PHASES + 3);
    $display("incl. no-idle stretch, long output stall and a mid-run drain");
    if (errors == 0 && routes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
